FILE: hdl/fspc_pkg.sv
// Shared types and constants for the five-stage pipeline core.
`timescale 1ns / 1ps

package fspc_pkg;

  localparam int DATA_WORDS     = 256;
  localparam int DM_AW          = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int REGISTER_COUNT = 8;
  localparam int RF_AW          = $clog2(REGISTER_COUNT);

  localparam int IN_W  = 24;
  localparam int OUT_W = 48;

  // Opcodes.
  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_JUMP  = 4'd2;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;

  // ALU operations; R-type funct codes map onto these directly.
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SUB  = 3'd2;
  localparam logic [2:0] ALU_AND  = 3'd4;
  localparam logic [2:0] ALU_OR   = 3'd5;
  localparam logic [2:0] ALU_NONE = 3'd7;

  typedef struct packed {
    logic        valid;
    logic [15:0] word;
    logic [11:0] pc_next;
  } fd_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  alu_op;
    logic        use_imm;
    logic        is_branch;
    logic        is_jump;
    logic        mem_write;
    logic        reg_write;
    logic        from_mem;
    logic [2:0]  dest;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [5:0]  imm;
    logic [11:0] pc_next;
    logic [11:0] target;
  } de_t;

  typedef struct packed {
    logic        valid;
    logic        is_branch;
    logic        is_jump;
    logic        mem_write;
    logic        reg_write;
    logic        from_mem;
    logic        zero;
    logic [2:0]  dest;
    logic [7:0]  result;
    logic [7:0]  store_data;
    logic [11:0] branch_pc;
    logic [11:0] target;
  } em_t;

  typedef struct packed {
    logic       valid;
    logic       reg_write;
    logic       from_mem;
    logic [2:0] dest;
    logic [7:0] result;
    logic [7:0] loaded;
  } mw_t;

endpackage

FILE: hdl/fspc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/five_stage_pipeline_core.sv
// Five-stage in-order pipeline core: latches, register file and data memory around them.
// A request's result sits in the output register in the cycle after it is accepted.
// Throughput: one request per cycle unless the output stalls; each advances all five stages by one step.
// Register file and data memory are synchronous RAMs read one request ahead, with
// forwarding of the write done in the same cycle as the read.
// Reset clears pc, stage latches and per-entry valid bits at once; no clearing pass.
`timescale 1ns / 1ps

module five_stage_pipeline_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [0] instr_valid, [16:1] instr_word, [23:17] zero
  input  logic [fspc_pkg::IN_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [11:0] next_pc, [12] redirect, [13] reg_write_valid, [16:14] reg_write_index,
  // [24:17] reg_write_value, [25] mem_write_valid, [33:26] mem_write_address,
  // [41:34] mem_write_value, [42] alu_overflow, [47:43] zero
  output logic [fspc_pkg::OUT_W-1:0] out_tdata
);

  logic acc;

  fspc_pkg::fd_t fd_r, fd_nxt;
  fspc_pkg::de_t de_r, de_nxt;
  fspc_pkg::em_t em_r, em_nxt;
  fspc_pkg::mw_t mw_r, mw_nxt;
  logic [11:0]   pc_r, pc_nxt;

  logic                        out_valid_r;
  logic [fspc_pkg::OUT_W-1:0]  out_data_r, out_data_nxt;

  // register file side
  logic [fspc_pkg::REGISTER_COUNT-1:0] rf_vld_r;
  logic                                wb_en;
  logic [7:0]                          wb_val;
  logic [2:0]                          in_rs, in_rt, fd_rs, fd_rt;
  logic [7:0]                          rf_rdata_a, rf_rdata_b;
  logic                                rf_hit_a_r, rf_hit_b_r, rf_vld_a_r, rf_vld_b_r;
  logic [7:0]                          rf_fwd_r;
  logic [7:0]                          reg_a, reg_b;

  // data memory side
  logic [fspc_pkg::DATA_WORDS-1:0] dm_vld_r;
  logic                            st_inrange, st_en, rd_inrange;
  logic [fspc_pkg::DM_AW-1:0]      st_idx, rd_idx;
  logic [7:0]                      dm_rdata;
  logic                            dm_hit_r, dm_vld_rd_r, dm_inrange_r;
  logic [7:0]                      dm_fwd_r;
  logic [7:0]                      mem_load;

  // execute
  logic [8:0] alu_x, alu_y, alu_sum, alu_dif;
  logic [7:0] alu_res;
  logic       alu_ovf;

  logic redir;

  assign in_tready  = !out_valid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- write-back
  assign wb_en  = mw_r.valid && mw_r.reg_write;
  assign wb_val = mw_r.from_mem ? mw_r.loaded : mw_r.result;

  // ---------------- memory
  assign st_inrange = ({1'b0, em_r.result} < 9'(fspc_pkg::DATA_WORDS));
  assign st_en      = em_r.valid && em_r.mem_write && st_inrange;
  assign st_idx     = em_r.result[fspc_pkg::DM_AW-1:0];

  always_comb begin
    priority if (!dm_inrange_r) begin
      mem_load = 8'd0;
    end else if (dm_hit_r) begin
      mem_load = dm_fwd_r;
    end else if (dm_vld_rd_r) begin
      mem_load = dm_rdata;
    end else begin
      mem_load = 8'd0;
    end
  end

  always_comb begin
    mw_nxt = '0;
    redir  = 1'b0;
    pc_nxt = pc_r;
    if (em_r.valid) begin
      mw_nxt.valid     = 1'b1;
      mw_nxt.reg_write = em_r.reg_write;
      mw_nxt.from_mem  = em_r.from_mem;
      mw_nxt.dest      = em_r.dest;
      mw_nxt.result    = em_r.result;
      mw_nxt.loaded    = mem_load;
      priority if (em_r.is_jump) begin
        pc_nxt = em_r.target;
        redir  = 1'b1;
      end else if (em_r.is_branch && em_r.zero) begin
        pc_nxt = em_r.branch_pc;
        redir  = 1'b1;
      end else begin
        pc_nxt = pc_r;
      end
    end
    // fetch: the redirect target beats the increment
    if (in_tdata[0] && !redir) begin
      pc_nxt = pc_r + 12'd1;
    end
  end

  // ---------------- execute
  assign alu_x   = {de_r.a[7], de_r.a};
  assign alu_y   = de_r.use_imm ? {{3{de_r.imm[5]}}, de_r.imm} : {de_r.b[7], de_r.b};
  assign alu_sum = alu_x + alu_y;
  assign alu_dif = alu_x - alu_y;

  always_comb begin
    alu_res = 8'd0;
    alu_ovf = 1'b0;
    unique case (de_r.alu_op)
      fspc_pkg::ALU_ADD: begin
        alu_res = alu_sum[7:0];
        alu_ovf = alu_sum[8] ^ alu_sum[7];
      end
      fspc_pkg::ALU_SUB: begin
        alu_res = alu_dif[7:0];
        alu_ovf = alu_dif[8] ^ alu_dif[7];
      end
      fspc_pkg::ALU_AND: alu_res = alu_x[7:0] & alu_y[7:0];
      fspc_pkg::ALU_OR:  alu_res = alu_x[7:0] | alu_y[7:0];
      default: begin
        alu_res = 8'd0;
        alu_ovf = 1'b0;
      end
    endcase
  end

  always_comb begin
    em_nxt = '0;
    if (de_r.valid) begin
      em_nxt.valid      = 1'b1;
      em_nxt.result     = alu_res;
      em_nxt.zero       = (alu_res == 8'd0);
      em_nxt.is_branch  = de_r.is_branch;
      em_nxt.is_jump    = de_r.is_jump;
      em_nxt.mem_write  = de_r.mem_write;
      em_nxt.reg_write  = de_r.reg_write;
      em_nxt.from_mem   = de_r.from_mem;
      em_nxt.dest       = de_r.dest;
      em_nxt.store_data = de_r.b;
      em_nxt.branch_pc  = de_r.pc_next + {{6{de_r.imm[5]}}, de_r.imm};
      em_nxt.target     = de_r.target;
    end
  end

  // issue the load read one request ahead, at the address execute produces now
  assign rd_inrange = ({1'b0, em_nxt.result} < 9'(fspc_pkg::DATA_WORDS));
  assign rd_idx     = em_nxt.result[fspc_pkg::DM_AW-1:0];

  // ---------------- decode
  assign fd_rs = fd_r.word[11:9];
  assign fd_rt = fd_r.word[8:6];

  always_comb begin
    priority if (wb_en && mw_r.dest == fd_rs) begin
      reg_a = wb_val;
    end else if (rf_hit_a_r) begin
      reg_a = rf_fwd_r;
    end else if (rf_vld_a_r) begin
      reg_a = rf_rdata_a;
    end else begin
      reg_a = 8'd0;
    end
    priority if (wb_en && mw_r.dest == fd_rt) begin
      reg_b = wb_val;
    end else if (rf_hit_b_r) begin
      reg_b = rf_fwd_r;
    end else if (rf_vld_b_r) begin
      reg_b = rf_rdata_b;
    end else begin
      reg_b = 8'd0;
    end
  end

  always_comb begin
    de_nxt = '0;
    if (fd_r.valid) begin
      de_nxt.valid   = 1'b1;
      de_nxt.pc_next = fd_r.pc_next;
      de_nxt.a       = reg_a;
      de_nxt.b       = reg_b;
      de_nxt.imm     = fd_r.word[5:0];
      de_nxt.dest    = fd_rt;
      unique case (fd_r.word[15:12])
        fspc_pkg::OP_RTYPE: begin
          de_nxt.alu_op    = fd_r.word[2:0];
          de_nxt.reg_write = 1'b1;
          de_nxt.dest      = fd_r.word[5:3];
        end
        fspc_pkg::OP_ADDI: begin
          de_nxt.alu_op    = fspc_pkg::ALU_ADD;
          de_nxt.use_imm   = 1'b1;
          de_nxt.reg_write = 1'b1;
        end
        fspc_pkg::OP_LW: begin
          de_nxt.alu_op    = fspc_pkg::ALU_ADD;
          de_nxt.use_imm   = 1'b1;
          de_nxt.reg_write = 1'b1;
          de_nxt.from_mem  = 1'b1;
        end
        fspc_pkg::OP_SW: begin
          de_nxt.alu_op    = fspc_pkg::ALU_ADD;
          de_nxt.use_imm   = 1'b1;
          de_nxt.mem_write = 1'b1;
        end
        fspc_pkg::OP_BEQ: begin
          de_nxt.alu_op    = fspc_pkg::ALU_SUB;
          de_nxt.is_branch = 1'b1;
        end
        fspc_pkg::OP_JUMP: begin
          de_nxt.alu_op  = fspc_pkg::ALU_NONE;
          de_nxt.is_jump = 1'b1;
          de_nxt.target  = fd_r.word[11:0];
        end
        default: de_nxt = '0;  // unknown opcode: drop to a bubble
      endcase
    end
  end

  // ---------------- fetch
  assign in_rs = in_tdata[12:10];
  assign in_rt = in_tdata[9:7];

  always_comb begin
    fd_nxt = '0;
    if (in_tdata[0]) begin
      fd_nxt.valid   = 1'b1;
      fd_nxt.word    = in_tdata[16:1];
      fd_nxt.pc_next = pc_r + 12'd1;
    end
  end

  // ---------------- result
  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt[11:0]    = pc_nxt;
    out_data_nxt[12]      = redir;
    out_data_nxt[13]      = wb_en;
    out_data_nxt[16:14]   = wb_en ? mw_r.dest : 3'd0;
    out_data_nxt[24:17]   = wb_en ? wb_val : 8'd0;
    out_data_nxt[25]      = st_en;
    out_data_nxt[33:26]   = (em_r.valid && em_r.mem_write) ? em_r.result : 8'd0;
    out_data_nxt[41:34]   = (em_r.valid && em_r.mem_write) ? em_r.store_data : 8'd0;
    out_data_nxt[42]      = de_r.valid && alu_ovf;
  end

  // ---------------- memories
  fspc_ram #(.WIDTH(8), .DEPTH(fspc_pkg::REGISTER_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (acc && wb_en),
    .waddr (mw_r.dest),
    .wdata (wb_val),
    .re    (acc),
    .raddr (in_rs),
    .rdata (rf_rdata_a)
  );

  fspc_ram #(.WIDTH(8), .DEPTH(fspc_pkg::REGISTER_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (acc && wb_en),
    .waddr (mw_r.dest),
    .wdata (wb_val),
    .re    (acc),
    .raddr (in_rt),
    .rdata (rf_rdata_b)
  );

  fspc_ram #(.WIDTH(8), .DEPTH(fspc_pkg::DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (acc && st_en),
    .waddr (st_idx),
    .wdata (em_r.store_data),
    .re    (acc),
    .raddr (rd_idx),
    .rdata (dm_rdata)
  );

  // ---------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r        <= '0;
      de_r        <= '0;
      em_r        <= '0;
      mw_r        <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
      dm_vld_r    <= '0;
    end else begin
      if (acc) begin
        fd_r        <= fd_nxt;
        de_r        <= de_nxt;
        em_r        <= em_nxt;
        mw_r        <= mw_nxt;
        pc_r        <= pc_nxt;
        out_valid_r <= 1'b1;
        if (wb_en) begin
          rf_vld_r[mw_r.dest] <= 1'b1;
        end
        if (st_en) begin
          dm_vld_r[st_idx] <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // read-side capture: hold until the next request
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r   <= out_data_nxt;
      rf_hit_a_r   <= wb_en && mw_r.dest == in_rs;
      rf_hit_b_r   <= wb_en && mw_r.dest == in_rt;
      rf_fwd_r     <= wb_val;
      rf_vld_a_r   <= rf_vld_r[in_rs];
      rf_vld_b_r   <= rf_vld_r[in_rt];
      dm_hit_r     <= st_en && rd_inrange && st_idx == rd_idx;
      dm_fwd_r     <= em_r.store_data;
      dm_vld_rd_r  <= rd_inrange && dm_vld_r[rd_idx];
      dm_inrange_r <= rd_inrange;
    end
  end

  // ---------------- assertions
  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted request produced no result");

  a_bubble_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_tdata[0] |=> !fd_r.valid)
    else $error("bubble did not reach decode latch");

  a_pc_increment: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tdata[0] && !redir |=> pc_r == $past(pc_r) + 12'd1)
    else $error("pc did not advance on fetch");

  a_dm_fwd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    dm_hit_r |-> dm_inrange_r)
    else $error("data memory forward hit outside range");

endmodule
